// ===== rtl/core/lag_pkg.sv =====
// Shared constants, codes and types of the life automaton generation unit.
`default_nettype none
package lag_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int GRID_W   = 64;
  localparam int ADDR_W   = $clog2(MAX_ROWS);
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_value;
  } lag_in_t;

  typedef struct packed {
    logic [5:0]        row_index;
    logic [GRID_W-1:0] row_bits;
    logic              last_row;
  } lag_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_PRIME,
    ST_LOAD,
    ST_SWEEP
  } lag_state_t;

  typedef enum logic [1:0] {
    RD_ITEM,
    RD_FIRST,
    RD_SECOND,
    RD_AHEAD
  } lag_rd_sel_t;

  typedef struct packed {
    logic        capture;
    logic        ram_rd;
    lag_rd_sel_t rd_sel;
    logic        load_window;
    logic        advance;
    logic        set_wr;
  } lag_cmd_t;

  typedef struct packed {
    logic in_range;
    logic last;
    logic slot_free;
  } lag_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/life_automaton_generation_unit.sv =====
// Top level of the B3/S23 life automaton generation unit.
//
//  channel | direction | handshake              | payload
//  in_     | request   | in_valid / in_stall    | lag_in_t  (op, row, col, cell_value)
//  out_    | result    | out_valid / out_stall  | lag_out_t (row_index, row_bits, last_row)
//  cfg_    | write     | cfg_we                 | cfg_index, cfg_wdata (7 bits)
//
// Set request: a row read, then a write back through the single grid RAM.
// Step or dump request: one row per cycle while out_stall is low, paced by the
// one read port of the grid RAM feeding a three-row sliding window.
// out_stall pauses the row sweep; the next request is taken while the last row waits.
// Reset clears the grid at once through per-row valid flags; no clearing pass.
`default_nettype none
module life_automaton_generation_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire lag_pkg::lag_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output lag_pkg::lag_out_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [lag_pkg::CFG_W-1:0] cfg_wdata
);
  import lag_pkg::*;

  lag_cmd_t  cmd;
  lag_stat_t stat;

  lag_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_data.op),
    .in_stall(in_stall),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  lag_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lag_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lag_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lag_datapath.sv =====
// Datapath: config registers, grid RAM, row window, B3/S23 row logic, output register.
`default_nettype none
module lag_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lag_pkg::lag_in_t           in_data,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [lag_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire lag_pkg::lag_cmd_t          cmd_i,
  output lag_pkg::lag_stat_t              stat_o,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output lag_pkg::lag_out_t               out_data
);
  import lag_pkg::*;

  logic [CFG_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic [CFG_W-1:0]  nr_eff, nc_eff;
  logic [GRID_W-1:0] col_mask;

  lag_in_t           item_r;
  logic [ADDR_W-1:0] row_r, row_nxt;
  logic [GRID_W-1:0] prev_r, prev_nxt;
  logic [GRID_W-1:0] cur_r, cur_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [GRID_W-1:0] ram_wdata, ram_rdata;
  logic [MAX_ROWS-1:0] row_valid_r;
  logic              rvalid_r;
  logic [GRID_W-1:0] rd_row;

  logic              has_next, is_last, in_range, slot_free, is_step;
  logic [GRID_W-1:0] p_m, u_m, n_m;
  logic [GRID_W-1:0] p_l, p_rt, u_l, u_rt, n_l, n_rt;
  logic [GRID_W-1:0] life, new_row, set_word, emit_bits;
  logic [3:0]        cnt;

  logic              out_valid_r;
  lag_out_t          out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_RESET;
      cols_cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE: rows_cfg_r <= cfg_wdata;
        REG_COLS_IN_USE: cols_cfg_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    nr_eff = rows_cfg_r;
    if (rows_cfg_r == '0) nr_eff = CFG_W'(1);
    else if (rows_cfg_r > CFG_W'(MAX_ROWS)) nr_eff = CFG_W'(MAX_ROWS);
    nc_eff = cols_cfg_r;
    if (cols_cfg_r == '0) nc_eff = CFG_W'(1);
    else if (cols_cfg_r > CFG_W'(MAX_COLS)) nc_eff = CFG_W'(MAX_COLS);
    for (int c = 0; c < GRID_W; c++) begin
      col_mask[c] = (CFG_W'(c) < nc_eff);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      item_r <= in_data;
    end
  end

  assign is_step  = (item_r.op == OP_STEP);
  assign in_range = (CFG_W'(item_r.row) < nr_eff) && (CFG_W'(item_r.col) < nc_eff);
  assign has_next = (CFG_W'(row_r) + CFG_W'(1)) < nr_eff;
  assign is_last  = (CFG_W'(row_r) + CFG_W'(1)) == nr_eff;

  // grid storage; rows never written since reset read as dead
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ITEM:   ram_raddr = item_r.row[ADDR_W-1:0];
      RD_FIRST:  ram_raddr = '0;
      RD_SECOND: ram_raddr = ADDR_W'(1);
      RD_AHEAD:  ram_raddr = row_r + ADDR_W'(2);
    endcase
  end

  assign ram_re    = cmd_i.ram_rd;
  assign ram_we    = cmd_i.set_wr | (cmd_i.advance & is_step);
  assign ram_waddr = cmd_i.set_wr ? item_r.row[ADDR_W-1:0] : row_r;
  assign ram_wdata = cmd_i.set_wr ? set_word : new_row;

  lag_ram #(
    .WIDTH(GRID_W),
    .DEPTH(MAX_ROWS)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (ram_we) begin
        row_valid_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rvalid_r <= row_valid_r[ram_raddr];
      end
    end
  end

  assign rd_row = rvalid_r ? ram_rdata : '0;

  assign set_word = (rd_row & ~(GRID_W'(1) << item_r.col))
                  | (GRID_W'(item_r.cell_value) << item_r.col);

  // row window: prev (masked), cur (raw), next from RAM
  always_comb begin
    row_nxt  = row_r;
    prev_nxt = prev_r;
    cur_nxt  = cur_r;
    if (cmd_i.load_window) begin
      row_nxt  = '0;
      prev_nxt = '0;
      cur_nxt  = rd_row;
    end else if (cmd_i.advance) begin
      row_nxt  = row_r + ADDR_W'(1);
      prev_nxt = u_m;
      cur_nxt  = rd_row;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
  end

  // B3/S23 for one row
  assign p_m  = prev_r;
  assign u_m  = cur_r & col_mask;
  assign n_m  = has_next ? (rd_row & col_mask) : '0;
  assign p_l  = p_m << 1;
  assign p_rt = p_m >> 1;
  assign u_l  = u_m << 1;
  assign u_rt = u_m >> 1;
  assign n_l  = n_m << 1;
  assign n_rt = n_m >> 1;

  always_comb begin
    cnt  = '0;
    life = '0;
    for (int c = 0; c < GRID_W; c++) begin
      cnt = 4'(p_l[c]) + 4'(p_m[c]) + 4'(p_rt[c]) + 4'(u_l[c]) + 4'(u_rt[c])
          + 4'(n_l[c]) + 4'(n_m[c]) + 4'(n_rt[c]);
      life[c] = (cnt == 4'd3) || ((cnt == 4'd2) && u_m[c]);
    end
  end

  assign new_row   = (life & col_mask) | (cur_r & ~col_mask);
  assign emit_bits = (is_step ? new_row : cur_r) & col_mask;

  // output register
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.advance) begin
      out_data_r.row_index <= 6'(row_r);
      out_data_r.row_bits  <= emit_bits;
      out_data_r.last_row  <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat_o.in_range  = in_range;
  assign stat_o.last      = is_last;
  assign stat_o.slot_free = slot_free;

  a_wr_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CFG_W'(ram_waddr) < nr_eff))
    else $error("grid write outside rows in use");

  a_adv_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.advance |-> slot_free)
    else $error("row emitted into occupied output register");

  a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.advance && !is_last) |=> (row_r == $past(row_r) + ADDR_W'(1)))
    else $error("row counter skipped");

endmodule
`default_nettype wire

// ===== rtl/core/lag_ctrl.sv =====
// Controller: sequences set, step and dump requests over the grid datapath.
`default_nettype none
module lag_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_op,
  output logic                    in_stall,
  output lag_pkg::lag_cmd_t       cmd_o,
  input  wire lag_pkg::lag_stat_t stat_i
);
  import lag_pkg::*;

  lag_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op) inside
            OP_SET:           state_nxt = ST_SET_RD;
            OP_STEP, OP_DUMP: state_nxt = ST_PRIME;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SET_RD: state_nxt = stat_i.in_range ? ST_SET_WR : ST_IDLE;
      ST_SET_WR: state_nxt = ST_IDLE;
      ST_PRIME:  state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (stat_i.slot_free && stat_i.last) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd_o.capture = in_valid;
      end
      ST_SET_RD: begin
        cmd_o.ram_rd = 1'b1;
        cmd_o.rd_sel = RD_ITEM;
      end
      ST_SET_WR: begin
        cmd_o.set_wr = 1'b1;
      end
      ST_PRIME: begin
        cmd_o.ram_rd = 1'b1;
        cmd_o.rd_sel = RD_FIRST;
      end
      ST_LOAD: begin
        cmd_o.ram_rd      = 1'b1;
        cmd_o.rd_sel      = RD_SECOND;
        cmd_o.load_window = 1'b1;
      end
      ST_SWEEP: begin
        cmd_o.advance = stat_i.slot_free;
        cmd_o.ram_rd  = stat_i.slot_free;
        cmd_o.rd_sel  = RD_AHEAD;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_set_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SET_WR) |-> ($past(state_r) == ST_SET_RD))
    else $error("cell write without prior row read");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && cmd_o.advance && stat_i.last) |=> (state_r == ST_IDLE))
    else $error("sweep ran past last row");

  a_set_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_SET) |=> (state_r == ST_SET_RD))
    else $error("set request not started");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the life automaton generation unit (B3/S23 grid, set/step/dump).
`default_nettype none
module testbench;
  import lag_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;

  class life_predictor;
    logic [GRID_W-1:0] grid [MAX_ROWS] = '{default: '0};
    logic [CFG_W-1:0]  rows_reg = CFG_RESET;
    logic [CFG_W-1:0]  cols_reg = CFG_RESET;
    lag_out_t          expected_rows [$];
    int errors, rows_checked, sets, steps, dumps;

    function int clamp_size(logic [CFG_W-1:0] v, int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return int'(v);
    endfunction

    function int used_rows();
      return clamp_size(rows_reg, MAX_ROWS);
    endfunction

    function int used_cols();
      return clamp_size(cols_reg, MAX_COLS);
    endfunction

    function logic [GRID_W-1:0] col_mask(int nc);
      if (nc >= GRID_W) return '1;
      return (64'd1 << nc) - 64'd1;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_ROWS_IN_USE) rows_reg = val;
      else cols_reg = val;
    endfunction

    function int live_neighbors(int r, int c, int nr, int nc);
      int n;
      n = 0;
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++)
          if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr && c + dc >= 0 &&
              c + dc < nc)
            n += grid[r + dr][c + dc];
      return n;
    endfunction

    function void advance(int nr, int nc);
      logic [GRID_W-1:0] nxt [MAX_ROWS];
      int n;
      for (int r = 0; r < nr; r++) begin
        nxt[r] = grid[r] & ~col_mask(nc);
        for (int c = 0; c < nc; c++) begin
          n = live_neighbors(r, c, nr, nc);
          if (n == 3 || (n == 2 && grid[r][c])) nxt[r][c] = 1'b1;
        end
      end
      for (int r = 0; r < nr; r++) grid[r] = nxt[r];
    endfunction

    function void emit(int nr, int nc);
      lag_out_t o;
      for (int r = 0; r < nr; r++) begin
        o.row_index = r[5:0];
        o.row_bits  = grid[r] & col_mask(nc);
        o.last_row  = (r == nr - 1);
        expected_rows.push_back(o);
      end
    endfunction

    function void note_request(lag_in_t req);
      int nr, nc;
      nr = used_rows();
      nc = used_cols();
      case (req.op)
        OP_SET: begin
          sets++;
          if (req.row < nr && req.col < nc) grid[req.row][req.col] = req.cell_value;
        end
        OP_STEP: begin
          steps++;
          advance(nr, nc);
          emit(nr, nc);
        end
        OP_DUMP: begin
          dumps++;
          emit(nr, nc);
        end
        default: ;
      endcase
    endfunction

    function void check_row(lag_out_t got);
      lag_out_t want;
      if (expected_rows.size() == 0) begin
        errors++;
        $display("%0t: expected no row, got index %0d bits %h last %0b", $time,
                 got.row_index, got.row_bits, got.last_row);
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (got.row_index !== want.row_index || got.row_bits !== want.row_bits ||
          got.last_row !== want.last_row) begin
        errors++;
        $display("%0t: row mismatch, expected index %0d bits %h last %0b,",
                 $time, want.row_index, want.row_bits, want.last_row,
                 " got index %0d bits %h last %0b",
                 got.row_index, got.row_bits, got.last_row);
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lag_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lag_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_ROWS_IN_USE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  idle_mode_t    mode = IDLE_NONE;
  logic          hold_request = 1'b0;
  logic          hold_done = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  life_predictor sb;

  life_automaton_generation_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_pct(idle_mode_t m, bit receiver_side);
    if (m == IDLE_BOTH) return 12;
    if (m == (receiver_side ? IDLE_RECEIVER : IDLE_SENDER)) return 47;
    return 0;
  endfunction

  // result side: check, then pick next stall; long hold counted here
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_row(out_data);
    if (hold_request && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct(mode, 1'b1));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input lag_in_t req);
    while ($urandom_range(0, 99) < idle_pct(mode, 1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic send_op(input logic [1:0] op, input int r, input int c, input bit v);
    lag_in_t req;
    req.op = op;
    req.row = r[5:0];
    req.col = c[5:0];
    req.cell_value = v;
    send_request(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] rows_v, input logic [CFG_W-1:0] cols_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_wdata <= rows_v;
    @(posedge clk);
    sb.write_reg(REG_ROWS_IN_USE, rows_v);
    cfg_index <= REG_COLS_IN_USE;
    cfg_wdata <= cols_v;
    @(posedge clk);
    sb.write_reg(REG_COLS_IN_USE, cols_v);
    cfg_we <= 1'b0;
  endtask

  // mostly in-range sets that seed live patterns, some steps and dumps, a little noise
  function automatic lag_in_t random_request(output bit counts);
    lag_in_t req;
    int pick, nr, nc;
    nr = sb.used_rows();
    nc = sb.used_cols();
    pick = $urandom_range(0, 99);
    req = lag_in_t'($urandom);
    counts = 1'b1;
    if (pick < 62) begin
      req.op = OP_SET;
      req.row = 6'($urandom_range(0, nr - 1));
      req.col = 6'($urandom_range(0, nc - 1));
      req.cell_value = ($urandom_range(0, 99) < 60);
    end else if (pick < 70) begin
      req.op = OP_SET;
      counts = (req.row < nr && req.col < nc);
    end else if (pick < 75) begin
      req.op = OP_UNUSED;
      counts = 1'b0;
    end else if (pick < 92) begin
      req.op = OP_STEP;
    end else begin
      req.op = OP_DUMP;
    end
    return req;
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] rows_v, input logic [CFG_W-1:0] cols_v,
                           input idle_mode_t m, input int target, input bit squeeze);
    int useful;
    bit counts;
    lag_in_t req;
    drain();
    write_config(rows_v, cols_v);
    mode <= m;
    if (squeeze) begin
      hold_request <= 1'b1;
      // a dump right away parks a row in the output while requests keep coming
      send_op(OP_DUMP, 0, 0, 1'b0);
    end
    useful = 0;
    while (useful < target) begin
      req = random_request(counts);
      send_request(req);
      if (counts) useful++;
    end
  endtask

  initial begin
    sb = new;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, a blinker, a glider, a cell set then cleared, an unused op, then dumps and steps
    send_op(OP_SET, 0, 0, 1'b1);
    send_op(OP_SET, 63, 63, 1'b1);
    send_op(OP_SET, 0, 63, 1'b1);
    send_op(OP_SET, 63, 0, 1'b1);
    send_op(OP_SET, 10, 20, 1'b1);
    send_op(OP_SET, 10, 21, 1'b1);
    send_op(OP_SET, 10, 22, 1'b1);
    send_op(OP_SET, 30, 31, 1'b1);
    send_op(OP_SET, 31, 32, 1'b1);
    send_op(OP_SET, 32, 30, 1'b1);
    send_op(OP_SET, 32, 31, 1'b1);
    send_op(OP_SET, 32, 32, 1'b1);
    send_op(OP_SET, 5, 5, 1'b1);
    send_op(OP_SET, 5, 5, 1'b0);
    send_op(OP_UNUSED, 63, 63, 1'b1);
    send_op(OP_DUMP, 0, 0, 1'b0);
    send_op(OP_STEP, 63, 63, 1'b1);
    send_op(OP_STEP, 0, 0, 1'b0);
    send_op(OP_DUMP, 63, 63, 1'b1);

    run_phase(7'd1,   7'd1,  IDLE_SENDER,   8,  1'b0);
    run_phase(7'd0,   7'd0,  IDLE_RECEIVER, 6,  1'b0);
    run_phase(7'd3,   7'd3,  IDLE_BOTH,     12, 1'b0);
    run_phase(7'd127, 7'd65, IDLE_NONE,     8,  1'b0);
    run_phase(7'd8,   7'd5,  IDLE_SENDER,   12, 1'b0);
    run_phase(7'd5,   7'd64, IDLE_RECEIVER, 10, 1'b0);
    run_phase(7'd64,  7'd64, IDLE_NONE,     8,  1'b1);
    run_phase(7'd6,   7'd6,  IDLE_BOTH,     10, 1'b0);
    run_phase(7'd3,   7'd4,  IDLE_NONE,     8,  1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d sets, %0d steps and %0d dumps; %0d rows compared",
             sb.sets, sb.steps, sb.dumps, sb.rows_checked);
    $display("grids 1x1 to 64x64 incl. sizes 0 and 127, four idling patterns, one long hold");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/lag_pkg.sv
rtl/core/lag_ram.sv
rtl/core/lag_datapath.sv
rtl/core/lag_ctrl.sv
rtl/core/life_automaton_generation_unit.sv
tb/sv/testbench.sv
